@@ hw/rtl/button_debounce_longpress_core_assert.svh @@
// Assertion helpers for the button debounce block.
`ifndef BUTTON_DEBOUNCE_LONGPRESS_CORE_ASSERT_SVH
`define BUTTON_DEBOUNCE_LONGPRESS_CORE_ASSERT_SVH

// Same-cycle implication.
`define BDL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bdl assertion failed");

// Next-cycle implication.
`define BDL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bdl assertion failed");

`endif

@@ hw/rtl/bdl_pkg.sv @@
package bdl_pkg;

   localparam int BDL_BUTTON_COUNT = 4;
   localparam int TICK_W           = 16;
   localparam int CFG_W            = 15;
   localparam int PIN_W            = 4;
   localparam int BIDX_W           = 2;
   localparam int CSR_IDX_W        = 2;

   localparam logic [CFG_W-1:0] DEBOUNCE_RESET     = 15'd20;
   localparam logic [CFG_W-1:0] LONG_START_RESET   = 15'd512;
   localparam logic [CFG_W-1:0] LONG_REPEAT_RESET  = 15'd256;

   typedef enum logic [1:0] {
      PH_IDLE        = 2'd0,
      PH_DEBOUNCE    = 2'd1,
      PH_HELD        = 2'd2,
      PH_REL_DEBOUNCE = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      EV_NONE     = 2'd0,
      EV_PRESSED  = 2'd1,
      EV_RELEASED = 2'd2,
      EV_LONG     = 2'd3
   } event_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEBOUNCE    = 2'd0,
      CSR_LONG_START  = 2'd1,
      CSR_LONG_REPEAT = 2'd2
   } csr_reg_type;

   typedef struct packed {
      phase_type         phase;
      logic [TICK_W-1:0] deadline;
   } cell_type;

   typedef struct packed {
      logic [CFG_W-1:0] debounce;
      logic [CFG_W-1:0] long_start;
      logic [CFG_W-1:0] long_repeat;
   } cfg_type;

   // Deadline sum, wraps mod 2^16.
   function automatic logic [TICK_W-1:0] tick_after(logic [TICK_W-1:0] now,
                                                    logic [CFG_W-1:0]  ticks);
      return now + {1'b0, ticks};
   endfunction

   // Signed wraparound compare: strictly past.
   function automatic logic tick_passed(logic [TICK_W-1:0] now,
                                        logic [TICK_W-1:0] when);
      logic [TICK_W-1:0] diff;
      diff = now - when;
      return (diff != '0) && !diff[TICK_W-1];
   endfunction

endpackage

@@ hw/rtl/button_debounce_longpress_core.sv @@
// Channel | Dir | Handshake            | Payload (ports carry the channel prefix)
// --------+-----+----------------------+-----------------------------------------------
// req     | in  | req_valid, req_stall | now_ticks, pin_levels
// rsp     | out | rsp_valid, rsp_stall | button_index, event_code, all_idle, last_of_scan
// csr     | in  | csr_write_enable     | index, write_data
//
// A request (scan) rotates the ring of button cells past the single update unit,
// one button per cycle while the response register is not stalled.
// The next request is taken on the edge that handles the last button.
// A stalled response register freezes the ring; nothing is lost.
// Synchronous reset puts every button in idle and loads the default timings.
module button_debounce_longpress_core
   import bdl_pkg::*;
#(
   parameter int BUTTON_COUNT = BDL_BUTTON_COUNT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [TICK_W-1:0]    req_now_ticks,
   input  logic [PIN_W-1:0]     req_pin_levels,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [BIDX_W-1:0]    rsp_button_index,
   output logic [1:0]           rsp_event_code,
   output logic                 rsp_all_idle,
   output logic                 rsp_last_of_scan,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_write_data
);

   localparam int IDX_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUTTON_COUNT - 1);

   // Configuration registers.
   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_DEBOUNCE:    cfg_in.debounce    = csr_write_data;
            CSR_LONG_START:  cfg_in.long_start  = csr_write_data;
            CSR_LONG_REPEAT: cfg_in.long_repeat = csr_write_data;
            default:         cfg_in = cfg_ff;   // drop unmapped writes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{debounce: DEBOUNCE_RESET, long_start: LONG_START_RESET,
                     long_repeat: LONG_REPEAT_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Scan control.
   logic              busy_ff, busy_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              acc_ff, acc_in;       // all buttons idle so far this scan
   logic [TICK_W-1:0] now_ff, now_in;
   logic [PIN_W-1:0]  pin_ff, pin_in;

   logic accept, step, last_step;

   // Response register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BIDX_W-1:0] rsp_bidx_ff, rsp_bidx_in;
   logic [1:0]        rsp_ev_ff, rsp_ev_in;
   logic              rsp_idle_ff, rsp_idle_in;
   logic              rsp_last_ff, rsp_last_in;

   // Ring of button cells; cell 0 is the one at the update unit.
   cell_type  ring_q [BUTTON_COUNT];
   cell_type  upd_nxt;
   event_type upd_ev;

   // During a scan, advance one button whenever the response register is free or being drained.
   assign step      = busy_ff && (!rsp_valid_ff || !rsp_stall);
   assign last_step = step && (idx_ff == LAST_IDX);
   assign req_stall = busy_ff && !last_step;
   assign accept    = req_valid && !req_stall;

   bdl_update u_update (
      .cur      (ring_q[0]),
      .released (pin_ff[0]),
      .now      (now_ff),
      .cfg      (cfg_ff),
      .nxt      (upd_nxt),
      .ev       (upd_ev)
   );

   // Rotate: each cell takes its upper neighbor, the top takes the update result.
   for (genvar k = 0; k < BUTTON_COUNT; k++) begin : g_ring
      if (k == BUTTON_COUNT - 1) begin : g_top
         bdl_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (step),
            .cell_d   (upd_nxt),
            .cell_q   (ring_q[k])
         );
      end else begin : g_mid
         bdl_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (step),
            .cell_d   (ring_q[k+1]),
            .cell_q   (ring_q[k])
         );
      end
   end

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      acc_in  = acc_ff;
      now_in  = now_ff;
      pin_in  = pin_ff;
      if (step) begin
         idx_in = last_step ? '0 : idx_ff + 1'b1;
         acc_in = acc_ff && (upd_nxt.phase == PH_IDLE);
         // Shift pins down; buttons past the pin field read as released.
         pin_in = {1'b1, pin_ff[PIN_W-1:1]};
         if (last_step) busy_in = 1'b0;
      end
      if (accept) begin
         busy_in = 1'b1;
         idx_in  = '0;
         acc_in  = 1'b1;
         now_in  = req_now_ticks;
         pin_in  = req_pin_levels;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_bidx_in  = rsp_bidx_ff;
      rsp_ev_in    = rsp_ev_ff;
      rsp_idle_in  = rsp_idle_ff;
      rsp_last_in  = rsp_last_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
         rsp_bidx_in  = BIDX_W'(idx_ff);
         rsp_ev_in    = upd_ev;
         rsp_last_in  = (idx_ff == LAST_IDX);
         rsp_idle_in  = (idx_ff == LAST_IDX) && acc_ff && (upd_nxt.phase == PH_IDLE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         acc_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload: no reset.
   always_ff @(posedge clock) begin
      now_ff      <= now_in;
      pin_ff      <= pin_in;
      rsp_bidx_ff <= rsp_bidx_in;
      rsp_ev_ff   <= rsp_ev_in;
      rsp_idle_ff <= rsp_idle_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_button_index = rsp_bidx_ff;
   assign rsp_event_code   = rsp_ev_ff;
   assign rsp_all_idle     = rsp_idle_ff;
   assign rsp_last_of_scan = rsp_last_ff;

endmodule

@@ hw/rtl/bdl_cell.sv @@
module bdl_cell
   import bdl_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     shift_en,
   input  cell_type cell_d,
   output cell_type cell_q
);

   cell_type cell_ff;
   cell_type cell_in;

   // Take the neighbor's entry on a shift, hold otherwise.
   always_comb begin
      cell_in = shift_en ? cell_d : cell_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff <= '{phase: PH_IDLE, deadline: '0};
      end else begin
         cell_ff <= cell_in;
      end
   end

   assign cell_q = cell_ff;

endmodule

@@ hw/rtl/bdl_update.sv @@
module bdl_update
   import bdl_pkg::*;
(
   input  cell_type          cur,
   input  logic              released,
   input  logic [TICK_W-1:0] now,
   input  cfg_type           cfg,
   output cell_type          nxt,
   output event_type         ev
);

   logic passed;

   assign passed = tick_passed(now, cur.deadline);

   // Next phase.
   always_comb begin
      nxt.phase = cur.phase;
      case (cur.phase)
         PH_IDLE: begin
            if (!released) nxt.phase = PH_DEBOUNCE;
         end
         PH_DEBOUNCE: begin
            if (passed) nxt.phase = released ? PH_IDLE : PH_HELD;
         end
         PH_HELD: begin
            if (released) nxt.phase = PH_REL_DEBOUNCE;
         end
         PH_REL_DEBOUNCE: begin
            if (passed) nxt.phase = released ? PH_IDLE : PH_DEBOUNCE;
         end
         default: nxt.phase = PH_IDLE;
      endcase
   end

   // Event and deadline.
   always_comb begin
      ev           = EV_NONE;
      nxt.deadline = cur.deadline;
      case (cur.phase)
         PH_IDLE: begin
            if (!released) begin
               ev           = EV_PRESSED;
               nxt.deadline = tick_after(now, cfg.debounce);
            end
         end
         PH_DEBOUNCE: begin
            if (passed) begin
               if (released) ev = EV_RELEASED;
               else nxt.deadline = tick_after(now, cfg.long_start);
            end
         end
         PH_HELD: begin
            if (released) begin
               ev           = EV_RELEASED;
               nxt.deadline = tick_after(now, cfg.debounce);
            end else if (passed) begin
               ev           = EV_LONG;
               nxt.deadline = tick_after(now, cfg.long_repeat);
            end
         end
         PH_REL_DEBOUNCE: begin
            if (passed && !released) begin
               ev           = EV_PRESSED;
               nxt.deadline = tick_after(now, cfg.debounce);
            end
         end
         default: ev = EV_NONE;
      endcase
   end

endmodule

@@ hw/rtl/bdl_checker.sv @@
`include "button_debounce_longpress_core_assert.svh"

module bdl_checker
   import bdl_pkg::*;
#(
   parameter int BUTTON_COUNT = BDL_BUTTON_COUNT
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic [TICK_W-1:0]    req_now_ticks,
   input logic [PIN_W-1:0]     req_pin_levels,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [BIDX_W-1:0]    rsp_button_index,
   input logic [1:0]           rsp_event_code,
   input logic                 rsp_all_idle,
   input logic                 rsp_last_of_scan,
   input logic                 csr_write_enable,
   input logic [CSR_IDX_W-1:0] csr_index,
   input logic [CFG_W-1:0]     csr_write_data
);

   // A stalled response holds.
   `BDL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable({rsp_button_index, rsp_event_code, rsp_all_idle, rsp_last_of_scan}))

   // Within a scan the next button follows right after a taken response.
   `BDL_ASSERT_NEXT(a_next_button, clock, reset, rsp_valid && !rsp_stall && !rsp_last_of_scan, rsp_valid && (rsp_button_index == $past(rsp_button_index) + 2'd1))

   // The idle flag appears only on the last response of a scan.
   `BDL_ASSERT_NOW(a_idle_last, clock, reset, rsp_valid && rsp_all_idle, rsp_last_of_scan)

   // A press or long press leaves that button busy, so the bank cannot be idle.
   `BDL_ASSERT_NOW(a_idle_event, clock, reset, rsp_valid && rsp_all_idle, (rsp_event_code != EV_PRESSED) && (rsp_event_code != EV_LONG))

endmodule

bind button_debounce_longpress_core bdl_checker #(.BUTTON_COUNT(BUTTON_COUNT)) u_checker (.*);
